/* hdl/linear_probe_hash_table_assert.svh */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_assert
// Assertion macros used by the hash table RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define LPHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/lpht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Field widths, codes and the stored slot word of the hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // item field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;

  // request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_SEARCH = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    RES_OK      = 2'd0,
    RES_MISSING = 2'd1,
    RES_FULL    = 2'd2
  } result_e;

  // per-slot state
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_st_e;

  // one table entry as held in memory
  typedef struct packed {
    slot_st_e               st;
    logic [KEY_W-1:0]       key;
    logic [VALUE_W-1:0]     value;
  } slot_word_t;

endpackage
`default_nettype wire

/* hdl/lpht_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hdl/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one request item (action_i,
// key_i, value_i). Output channel: out_valid_o / out_stall_i carry one
// result item (status_o, found_value_o, slot_o) for every request.
// An item moves on a clock edge with valid high and stall low.
// The table sits in one RAM with a registered read. The accept
// cycle multiplies the key by the reciprocal of TABLE_SIZE, the next cycle
// forms key mod TABLE_SIZE and reads the home slot, then one probed slot
// is checked per cycle (1 to TABLE_SIZE probes, reads are streamed), and
// the result goes into the output register once that register is free or
// its result is taken. The next request is taken after that load. An
// unused action code skips the home read and the probes.
// One request is in work at a time; the output register lets a new
// request start while the previous result is still waiting.
// After reset a clearing pass marks all TABLE_SIZE slots empty, one per
// cycle; in_stall_o stays high during the pass.
// When the receiver stalls, a finished result waits inside until the
// output register frees up; the input stays stalled meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [lpht_pkg::ACTION_W-1:0]       action_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]          key_i,
  input  wire logic signed [lpht_pkg::VALUE_W-1:0] value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [lpht_pkg::STATUS_W-1:0]            status_o,
  output logic signed [lpht_pkg::VALUE_W-1:0]      found_value_o,
  output logic [lpht_pkg::SLOT_W-1:0]              slot_o
);

  import lpht_pkg::*;

`include "linear_probe_hash_table_assert.svh"

  localparam int unsigned IDX_W   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned WORD_W  = $bits(slot_word_t);
  localparam int unsigned PROD_W  = 2 * KEY_W + 1;
  localparam int unsigned HOME_SH = KEY_W + $clog2(TABLE_SIZE);

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
  // rounded-up reciprocal of TABLE_SIZE, exact quotient for every key
  localparam logic [KEY_W:0]    RECIP     = (KEY_W + 1)'(
    ((64'd1 << HOME_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_PROBE,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [IDX_W-1:0]      clr_idx_q;
  action_e               act_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_W-1:0]    val_q;
  logic [PROD_W-1:0]     prod_q;
  logic [KEY_W-1:0]      quo;
  logic [KEY_W-1:0]      rem_full;
  logic [IDX_W-1:0]      rem_d;
  logic [IDX_W-1:0]      chk_idx_q;
  logic [IDX_W-1:0]      nxt_idx;
  logic [IDX_W-1:0]      n_q;
  result_e               res_st_q;
  logic [VALUE_W-1:0]    res_val_q;
  logic [IDX_W-1:0]      res_slot_q;
  logic                  out_valid_q;
  logic                  out_load;
  result_e               out_st_q;
  logic [VALUE_W-1:0]    out_val_q;
  logic [IDX_W-1:0]      out_idx_q;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  slot_word_t            ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  slot_word_t            rd_word;

  logic                  fin;
  result_e               fin_st;
  logic [VALUE_W-1:0]    fin_val;
  logic [IDX_W-1:0]      fin_slot;
  logic                  pr_we;
  slot_word_t            pr_wdata;
  logic                  in_acc;

  // table memory
  lpht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (1 << IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_word = slot_word_t'(ram_rdata);
  assign in_acc  = in_valid_i && (state_q == S_IDLE);

  // home slot: key minus quotient times TABLE_SIZE
  assign quo      = KEY_W'(prod_q >> HOME_SH);
  assign rem_full = key_q - quo * KEY_W'(TABLE_SIZE);
  assign rem_d    = rem_full[IDX_W-1:0];

  // probe index with wrap-around
  assign nxt_idx = (chk_idx_q == LAST_IDX) ? '0 : chk_idx_q + IDX_W'(1);

  // probe decision on the slot whose read data is back
  always_comb begin
    fin      = 1'b0;
    fin_st   = RES_MISSING;
    fin_val  = '0;
    fin_slot = '0;
    pr_we    = 1'b0;
    pr_wdata = rd_word;
    case (act_q)
      ACT_INSERT: begin
        if (rd_word.st != SLOT_USED) begin
          fin            = 1'b1;
          fin_st         = RES_OK;
          fin_slot       = chk_idx_q;
          pr_we          = 1'b1;
          pr_wdata.st    = SLOT_USED;
          pr_wdata.key   = key_q;
          pr_wdata.value = val_q;
        end else if (n_q == LAST_IDX) begin
          fin    = 1'b1;
          fin_st = RES_FULL;
        end
      end
      ACT_SEARCH, ACT_DELETE: begin
        if (rd_word.st == SLOT_EMPTY) begin
          fin    = 1'b1;
          fin_st = RES_MISSING;
        end else if (rd_word.st == SLOT_USED && rd_word.key == key_q) begin
          fin      = 1'b1;
          fin_st   = RES_OK;
          fin_val  = rd_word.value;
          fin_slot = chk_idx_q;
          if (act_q == ACT_DELETE) begin
            pr_we       = 1'b1;
            pr_wdata.st = SLOT_TOMB;
          end
        end else if (n_q == LAST_IDX) begin
          fin    = 1'b1;
          fin_st = RES_MISSING;
        end
      end
      default: begin
        fin    = 1'b1;
        fin_st = RES_MISSING;
      end
    endcase
  end

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx_q;
    ram_wdata = pr_wdata;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = '0;
      end
      S_PROBE: begin
        ram_we = pr_we;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    case (state_q)
      S_HOME:  ram_raddr = rem_d;
      S_PROBE: ram_raddr = nxt_idx;
      default: ram_raddr = chk_idx_q;
    endcase
  end

  // output register takes a finished result when it is free or drained
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      act_q       <= ACT_SEARCH;
      key_q       <= '0;
      val_q       <= '0;
      prod_q      <= '0;
      chk_idx_q   <= '0;
      n_q         <= '0;
      res_st_q    <= RES_MISSING;
      res_val_q   <= '0;
      res_slot_q  <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= RES_OK;
      out_val_q   <= '0;
      out_idx_q   <= '0;
    end else begin
      // new result shown, or receiver takes the waiting one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + IDX_W'(1);
          if (clr_idx_q == LAST_IDX) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            act_q  <= action_e'(action_i);
            key_q  <= key_i;
            val_q  <= value_i;
            prod_q <= PROD_W'(key_i) * PROD_W'(RECIP);
            if (action_i == ACT_SEARCH || action_i == ACT_INSERT ||
                action_i == ACT_DELETE) begin
              state_q <= S_HOME;
            end else begin
              res_st_q   <= RES_MISSING;
              res_val_q  <= '0;
              res_slot_q <= '0;
              state_q    <= S_DONE;
            end
          end
        end
        S_HOME: begin
          chk_idx_q <= rem_d;
          n_q       <= '0;
          state_q   <= S_PROBE;
        end
        S_PROBE: begin
          if (fin) begin
            res_st_q   <= fin_st;
            res_val_q  <= fin_val;
            res_slot_q <= fin_slot;
            state_q    <= S_DONE;
          end else begin
            chk_idx_q <= nxt_idx;
            n_q       <= n_q + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_st_q  <= res_st_q;
            out_val_q <= res_val_q;
            out_idx_q <= res_slot_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // outputs
  assign slot_ext      = {SLOT_W'(0), out_idx_q};
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign found_value_o = out_val_q;
  assign slot_o        = slot_ext[SLOT_W-1:0];

  // checks
  `LPHT_ASSERT_IMP(a_we_state, ram_we, (state_q == S_CLEAR || state_q == S_PROBE),
    "table written outside clearing or probing")
  `LPHT_ASSERT_IMP(a_probe_wr_used, ram_we && state_q == S_PROBE,
    ram_wdata.st != SLOT_EMPTY, "probe write leaves slot empty")
  `LPHT_ASSERT_IMP(a_out_from_done, $rose(out_valid_o), $past(state_q) == S_DONE,
    "result shown without finished request")
  `LPHT_ASSERT_IMP(a_fail_zero, out_valid_o && status_o != RES_OK,
    (found_value_o == '0 && slot_o == '0), "failed request carries data")

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear probing hash table. Requests go in
// through the valid/stall input channel while a behavioral copy of the table
// predicts each result. A checker compares every result item field by field.
// Directed requests, random traffic under several idle/stall mixes and a
// full-table pass are run in turn.
// ----------------------------------------------------------------------------
module testbench;
  import lpht_pkg::*;

  localparam int unsigned TABLE_SIZE  = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 40;
  // action code outside the defined set
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    result_e            status;
    logic [VALUE_W-1:0] found_value;
    logic [SLOT_W-1:0]  slot;
  } table_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [ACTION_W-1:0]       action_i   = '0;
  logic [KEY_W-1:0]          key_i      = '0;
  logic signed [VALUE_W-1:0] value_i    = '0;

  // result channel
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [STATUS_W-1:0]       status_o;
  logic signed [VALUE_W-1:0] found_value_o;
  logic [SLOT_W-1:0]         slot_o;

  // behavioral copy of the table
  slot_st_e           table_state [TABLE_SIZE];
  logic [KEY_W-1:0]   table_key   [TABLE_SIZE];
  logic [VALUE_W-1:0] table_value [TABLE_SIZE];

  table_result_t pending_results [$];
  table_result_t head_result;
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   gap_pct     = 0;
  int unsigned   stall_pct   = 0;

  linear_probe_hash_table #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_value_o(found_value_o),
    .slot_o       (slot_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // apply one request to the table copy and return its result
  function automatic table_result_t apply_table_request(logic [ACTION_W-1:0] act,
                                                        logic [KEY_W-1:0] key,
                                                        logic [VALUE_W-1:0] value);
    table_result_t res;
    int unsigned   idx;
    bit            stop;
    bit            hit;
    res.status      = RES_MISSING;
    res.found_value = '0;
    res.slot        = '0;
    idx  = key % TABLE_SIZE;
    stop = 1'b0;
    hit  = 1'b0;
    case (act)
      ACT_SEARCH, ACT_DELETE: begin
        // probe until empty slot, match or one full pass
        for (int n = 0; n < TABLE_SIZE; n++) begin
          if (!stop) begin
            if (table_state[idx] == SLOT_EMPTY) begin
              stop = 1'b1;
            end else if (table_state[idx] == SLOT_USED && table_key[idx] == key) begin
              stop = 1'b1;
              hit  = 1'b1;
            end else begin
              idx = (idx + 1) % TABLE_SIZE;
            end
          end
        end
        if (hit) begin
          res.status      = RES_OK;
          res.found_value = table_value[idx];
          res.slot        = SLOT_W'(idx);
          if (act == ACT_DELETE) table_state[idx] = SLOT_TOMB;
        end
      end
      ACT_INSERT: begin
        // first empty or tombstone slot on the probe path
        res.status = RES_FULL;
        for (int n = 0; n < TABLE_SIZE; n++) begin
          if (!stop) begin
            if (table_state[idx] != SLOT_USED) begin
              stop               = 1'b1;
              table_state[idx]   = SLOT_USED;
              table_key[idx]     = key;
              table_value[idx]   = value;
              res.status         = RES_OK;
              res.slot           = SLOT_W'(idx);
            end else begin
              idx = (idx + 1) % TABLE_SIZE;
            end
          end
        end
      end
      default: begin
        // unused action code leaves the table alone
      end
    endcase
    return res;
  endfunction

  // send one request item, predict its result on acceptance
  task automatic send_request(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] key,
                              logic [VALUE_W-1:0] value);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= key;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_table_request(act, key, value));
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item status %0d value %h slot %0d",
                 $realtime, status_o, found_value_o, slot_o);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (status_o !== head_result.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   head_result.status, status_o);
          error_count++;
        end
        if (found_value_o !== head_result.found_value) begin
          $display("%0t: found_value expected %h actual %h", $realtime,
                   head_result.found_value, found_value_o);
          error_count++;
        end
        if (slot_o !== head_result.slot) begin
          $display("%0t: slot expected %0d actual %0d", $realtime,
                   head_result.slot, slot_o);
          error_count++;
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // hand-picked requests from an empty table
  task automatic test_directed();
    gap_pct   = 0;
    stall_pct = 0;
    // misses on an empty table and the unused code
    send_request(ACT_SEARCH, 31'd5, 32'd0);
    send_request(ACT_DELETE, 31'd5, 32'd0);
    send_request(ACT_UNUSED, 31'h7fffffff, 32'hffffffff);
    // extremes of key and value
    send_request(ACT_INSERT, 31'd0, 32'h80000000);
    send_request(ACT_INSERT, 31'h7fffffff, 32'h7fffffff);
    // collision on slot 0, then probing that wraps past the last slot
    send_request(ACT_INSERT, 31'd16, 32'd1);
    send_request(ACT_INSERT, 31'd31, 32'hffffffff);
    send_request(ACT_SEARCH, 31'd31, 32'd0);
    // delete leaves a tombstone that search passes over
    send_request(ACT_DELETE, 31'd0, 32'd0);
    send_request(ACT_SEARCH, 31'd16, 32'd0);
    send_request(ACT_SEARCH, 31'd0, 32'd0);
    // insert reuses the tombstone
    send_request(ACT_INSERT, 31'd48, 32'd0);
    // duplicate key: first copy is found, second after deleting the first
    send_request(ACT_INSERT, 31'd16, 32'd2);
    send_request(ACT_SEARCH, 31'd16, 32'd0);
    send_request(ACT_DELETE, 31'd16, 32'd0);
    send_request(ACT_SEARCH, 31'd16, 32'd0);
    // absent key whose probe runs into an empty slot
    send_request(ACT_SEARCH, 31'h7ffffff0, 32'd0);
    // alternating bit patterns
    send_request(ACT_INSERT, 31'h55555555, 32'haaaaaaaa);
    send_request(ACT_INSERT, 31'h2aaaaaaa, 32'h55555555);
    send_request(ACT_SEARCH, 31'h55555555, 32'd0);
    send_request(ACT_DELETE, 31'h2aaaaaaa, 32'd0);
    send_request(ACT_DELETE, 31'h7fffffff, 32'd0);
  endtask

  // one stretch of random requests, keys often taken from the table
  task automatic run_random_phase(int unsigned n_items, int unsigned gap,
                                  int unsigned stall);
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
    int unsigned         pick;
    gap_pct   = gap;
    stall_pct = stall;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) act = ACT_UNUSED;
      else if (pick < 45) act = ACT_INSERT;
      else if (pick < 75) act = ACT_SEARCH;
      else act = ACT_DELETE;
      if ($urandom_range(1)) key = KEY_W'($urandom());
      else key = table_key[$urandom_range(TABLE_SIZE - 1)];
      send_request(act, key, $urandom());
    end
  endtask

  // random traffic under each idle and stall mix
  task automatic test_random_traffic();
    run_random_phase(360, 0, 0);
    run_random_phase(360, 63, 0);
    run_random_phase(360, 0, 63);
    run_random_phase(360, 19, 19);
  endtask

  // fill every free slot, then insert, search and delete on a full table
  task automatic test_full_table();
    int unsigned      free_slots;
    logic [KEY_W-1:0] absent_key;
    bit               clash;
    gap_pct    = 19;
    stall_pct  = 19;
    free_slots = 0;
    foreach (table_state[i]) if (table_state[i] != SLOT_USED) free_slots++;
    repeat (free_slots) send_request(ACT_INSERT, KEY_W'($urandom()), $urandom());
    send_request(ACT_INSERT, KEY_W'($urandom()), $urandom());
    // a key held nowhere forces a full pass
    do begin
      absent_key = KEY_W'($urandom());
      clash      = 1'b0;
      foreach (table_key[i]) if (table_key[i] == absent_key) clash = 1'b1;
    end while (clash);
    send_request(ACT_SEARCH, absent_key, 32'd0);
    send_request(ACT_DELETE, absent_key, 32'd0);
    send_request(ACT_SEARCH, table_key[3], 32'd0);
  endtask

  // main sequence
  initial begin
    foreach (table_state[i]) begin
      table_state[i] = SLOT_EMPTY;
      table_key[i]   = '0;
      table_value[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_full_table();
    in_valid_i <= 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/linear_probe_hash_table.sv
test/testbench.sv
